[src/assert_macros.svh]
// Assertion helpers used by the checker in olist_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/olist_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package olist_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int VAL_W            = 32;
    localparam int POS_W            = 8;
    localparam int FPOS_W           = 6;
    localparam int CNT_OUT_W        = 7;

    typedef enum logic [2:0] {
        OP_ADD_FIRST = 3'd0,
        OP_ADD_LAST  = 3'd1,
        OP_ADD_AT    = 3'd2,
        OP_REM_FIRST = 3'd3,
        OP_REM_LAST  = 3'd4,
        OP_REM_AT    = 3'd5,
        OP_FIND      = 3'd6,
        OP_GET       = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_WR,
        S_PUT,
        S_DN_WR,
        S_FIND_CMP,
        S_GET_DATA,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[src/olist_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module olist_ram
    import olist_pkg::*;
#(
    parameter int DEPTH = DEFAULT_CAPACITY,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [VAL_W-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[src/ordered_list_engine.sv]
// Ordered list engine: a bounded list of signed 32-bit values held in one
// synchronous RAM, position 0 at the head.
// Input channel (s side): one beat is one operation, the opcode in tuser and
// the position and value in tdata. Output channel (m side): one beat per
// operation with the status in tuser and value read, found position and
// entry count in tdata.
// Steps: operations that only change the count or report an error go
// straight to the output register; an append writes the value and a get
// reads the entry first; add at position p shifts the entries from the tail
// down to p up by one and then writes the value; remove at p shifts the
// entries above p down by one (remove first is p = 0); find compares the
// entries from position 0 upward until one matches or the list ends.
// Shifts and searches touch one RAM entry per cycle through the single
// read port and the single write port; only one operation is in flight.
// The next beat is accepted the cycle after the result is loaded, even while
// that result still waits at the output.
// When the receiver stalls, the finished result holds in the output register
// and the engine waits with the next result until the register is free.
// Reset empties the list at once; the RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_engine
    import olist_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // position[7:0], value[39:8]
    input  wire logic [2:0]  i_s_tuser,   // op[2:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [47:0] o_m_tdata,   // value_read[31:0], found_position[37:32],
                                          // entry_count[44:38], zero[47:45]
    output logic      [2:0]  o_m_tuser    // status[2:0]
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_at, n_at;
    logic [VAL_W-1:0]   r_val, n_val;
    t_status            r_status, n_status;
    logic [VAL_W-1:0]   r_rd, n_rd;
    logic [FPOS_W-1:0]  r_fpos, n_fpos;
    logic               r_out_valid, n_out_valid;
    logic [47:0]        r_out_tdata, n_out_tdata;
    logic [2:0]         r_out_tuser, n_out_tuser;

    logic               w_accept;
    t_op                w_op;
    logic               w_neg;
    logic [15:0]        w_pos16;
    logic [15:0]        w_cnt16;
    logic [15:0]        w_idx16;
    logic [15:0]        w_at16;
    logic [AW-1:0]      w_pos_a;
    logic [AW-1:0]      w_add_at;
    logic               w_full;
    logic               w_load;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [VAL_W-1:0]   w_wdata;
    logic [AW-1:0]      w_raddr;
    logic [VAL_W-1:0]   w_rdata;

    olist_ram #(
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_op       = t_op'(i_s_tuser);
    assign w_neg      = i_s_tdata[POS_W-1];
    assign w_pos16    = 16'(i_s_tdata[POS_W-2:0]);
    assign w_pos_a    = AW'(i_s_tdata[POS_W-2:0]);
    assign w_cnt16    = 16'(r_count);
    assign w_idx16    = 16'(r_idx);
    assign w_full     = (w_cnt16 >= 16'(CAPACITY));
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    always_comb begin
        unique case (w_op)
            OP_ADD_FIRST: w_add_at = '0;
            OP_ADD_AT:    w_add_at = w_pos_a;
            default:      w_add_at = AW'(r_count);
        endcase
    end
    assign w_at16 = 16'(w_add_at);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tdata;
    assign o_m_tuser  = r_out_tuser;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_at     = r_at;
        n_val    = r_val;
        n_status = r_status;
        n_rd     = r_rd;
        n_fpos   = r_fpos;
        w_we     = 1'b0;
        w_waddr  = r_idx;
        w_wdata  = w_rdata;
        w_raddr  = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_val    = i_s_tdata[39:8];
                    n_status = ST_OK;
                    n_rd     = '0;
                    n_fpos   = '0;
                    n_state  = S_DONE;
                    unique case (w_op)
                        OP_ADD_FIRST, OP_ADD_LAST, OP_ADD_AT: begin
                            if ((w_op == OP_ADD_AT) && (w_neg || (w_pos16 > w_cnt16))) begin
                                n_status = ST_RANGE;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else if (w_at16 == w_cnt16) begin
                                n_at    = w_add_at;
                                n_state = S_PUT;
                            end else begin
                                n_at    = w_add_at;
                                n_idx   = AW'(r_count - 1'b1);
                                n_state = S_UP_RD;
                            end
                        end
                        OP_REM_FIRST: begin
                            if (w_cnt16 == 16'd1) begin
                                n_count = r_count - 1'b1;
                            end else if (w_cnt16 != 16'd0) begin
                                n_idx   = '0;
                                w_raddr = AW'(1);
                                n_state = S_DN_WR;
                            end
                        end
                        OP_REM_LAST: begin
                            if (w_cnt16 != 16'd0) begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_REM_AT, OP_GET: begin
                            if (w_neg) begin
                                n_status = ST_RANGE;
                            end else if (w_cnt16 == 16'd0) begin
                                n_status = ST_EMPTY;
                            end else if (w_pos16 >= w_cnt16) begin
                                n_status = ST_RANGE;
                            end else if (w_op == OP_GET) begin
                                w_raddr = w_pos_a;
                                n_state = S_GET_DATA;
                            end else if ((w_pos16 + 16'd1) == w_cnt16) begin
                                n_count = r_count - 1'b1;
                            end else begin
                                n_idx   = w_pos_a;
                                w_raddr = w_pos_a + 1'b1;
                                n_state = S_DN_WR;
                            end
                        end
                        OP_FIND: begin
                            if (w_cnt16 == 16'd0) begin
                                n_status = ST_NOTFOUND;
                            end else begin
                                n_idx   = '0;
                                w_raddr = '0;
                                n_state = S_FIND_CMP;
                            end
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                w_raddr = r_idx;
                n_state = S_UP_WR;
            end
            S_UP_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx + 1'b1;
                w_wdata = w_rdata;
                w_raddr = r_idx - 1'b1;
                if (r_idx == r_at) begin
                    n_state = S_PUT;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_at;
                w_wdata = r_val;
                n_count = r_count + 1'b1;
                n_state = S_DONE;
            end
            S_DN_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = w_rdata;
                w_raddr = r_idx + AW'(2);
                if ((w_idx16 + 16'd2) >= w_cnt16) begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FIND_CMP: begin
                w_raddr = r_idx + 1'b1;
                if (w_rdata == r_val) begin
                    n_fpos  = w_idx16[FPOS_W-1:0];
                    n_state = S_DONE;
                end else if ((w_idx16 + 16'd1) == w_cnt16) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_GET_DATA: begin
                n_rd    = w_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_tdata = r_out_tdata;
        n_out_tuser = r_out_tuser;
        if (w_load) begin
            n_out_valid = 1'b1;
            n_out_tdata = {3'b000, w_cnt16[CNT_OUT_W-1:0], r_fpos, r_rd};
            n_out_tuser = r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_at        <= n_at;
        r_val       <= n_val;
        r_status    <= n_status;
        r_rd        <= n_rd;
        r_fpos      <= n_fpos;
        r_out_tdata <= n_out_tdata;
        r_out_tuser <= n_out_tuser;
    end

endmodule

`default_nettype wire

[src/olist_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module olist_checker
    import olist_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [47:0] o_m_tdata,
    input wire logic [2:0]  o_m_tuser
);

    logic        w_in_beat;
    logic        w_out_stall;
    logic [50:0] w_out_bus;
    logic        w_count_in_range;
    logic        w_data_nz;

    assign w_in_beat        = i_s_tvalid && o_s_tready;
    assign w_out_stall      = o_m_tvalid && !i_m_tready;
    assign w_out_bus        = {o_m_tuser, o_m_tdata};
    assign w_count_in_range = (CAPACITY >= 128) || (32'(o_m_tdata[44:38]) <= 32'(CAPACITY));
    assign w_data_nz        = (o_m_tdata[37:0] != 38'd0);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_m_tvalid && $stable(w_out_bus))
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, w_in_beat, !o_s_tready)
    `ASSERT_IMP(a_count_bound, i_clk, i_rst_n, o_m_tvalid, w_count_in_range)
    `ASSERT_IMP(a_data_only_ok, i_clk, i_rst_n, o_m_tvalid && w_data_nz, o_m_tuser == ST_OK)

endmodule

bind ordered_list_engine olist_checker #(
    .CAPACITY(CAPACITY)
) u_olist_checker (.*);

`default_nettype wire

[tb/sv/ordered_list_checker.sv]
`timescale 1ns / 1ps

module ordered_list_checker
    import olist_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [39:0] i_s_tdata,   // position[7:0], value[39:8]
    input  wire logic [2:0]  i_s_tuser,   // op[2:0]
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [47:0] i_m_tdata,   // value_read[31:0], found_position[37:32],
                                          // entry_count[44:38], zero[47:45]
    input  wire logic [2:0]  i_m_tuser,   // status[2:0]
    output int               o_fail_count,
    output int               o_outstanding
);

    typedef struct packed {
        t_status     status;
        logic [31:0] value_read;
        logic [5:0]  found_position;
        logic [6:0]  entry_count;
    } t_list_result;

    logic [31:0]  list_mem [CAPACITY];
    int           list_len;
    t_list_result pending_results [$];
    int           mismatches;

    task automatic apply_operation(input t_op op, input logic [7:0] pos,
                                   input logic [31:0] val, output t_list_result res);
        int  at;
        int  idx;
        int  gone;
        bit  neg;
        res        = '0;
        res.status = ST_OK;
        neg        = pos[7];
        idx        = int'(pos[6:0]);
        gone       = -1;
        case (op)
            OP_ADD_FIRST, OP_ADD_LAST, OP_ADD_AT: begin
                at = (op == OP_ADD_FIRST) ? 0 : (op == OP_ADD_AT) ? idx : list_len;
                if (op == OP_ADD_AT && (neg || idx > list_len)) begin
                    res.status = ST_RANGE;
                end else if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (int k = list_len; k > at; k--) begin
                        list_mem[k] = list_mem[k - 1];
                    end
                    list_mem[at] = val;
                    list_len++;
                end
            end
            OP_REM_FIRST: begin
                if (list_len > 0) gone = 0;
            end
            OP_REM_LAST: begin
                if (list_len > 0) list_len--;
            end
            OP_REM_AT, OP_GET: begin
                if (neg) begin
                    res.status = ST_RANGE;
                end else if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (idx >= list_len) begin
                    res.status = ST_RANGE;
                end else if (op == OP_REM_AT) begin
                    gone = idx;
                end else begin
                    res.value_read = list_mem[idx];
                end
            end
            default: begin
                // Scanning downward leaves the lowest matching position.
                res.status = ST_NOTFOUND;
                for (int k = list_len - 1; k >= 0; k--) begin
                    if (list_mem[k] == val) begin
                        res.status         = ST_OK;
                        res.found_position = 6'(k);
                    end
                end
            end
        endcase
        if (gone >= 0) begin
            for (int k = gone; k + 1 < list_len; k++) begin
                list_mem[k] = list_mem[k + 1];
            end
            list_len--;
        end
        res.entry_count = 7'(list_len);
    endtask

    function automatic int field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_list_result seen;
        t_list_result want;
        if (!i_rst_n) begin
            list_len = 0;
            pending_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen = {t_status'(i_m_tuser), i_m_tdata[31:0], i_m_tdata[37:32],
                        i_m_tdata[44:38]};
                if (pending_results.size() == 0) begin
                    $error("result beat arrived with no operation pending");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    mismatches += field_differs("status", 32'(want.status),
                                                32'(seen.status));
                    mismatches += field_differs("value_read", want.value_read,
                                                seen.value_read);
                    mismatches += field_differs("found_position", 32'(want.found_position),
                                                32'(seen.found_position));
                    mismatches += field_differs("entry_count", 32'(want.entry_count),
                                                32'(seen.entry_count));
                    mismatches += field_differs("zero", 32'(0), 32'(i_m_tdata[47:45]));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_operation(t_op'(i_s_tuser), i_s_tdata[7:0], i_s_tdata[39:8], want);
                pending_results.push_back(want);
            end
        end
        o_outstanding <= pending_results.size();
        o_fail_count  <= mismatches;
    end

endmodule

[tb/sv/ordered_list_engine_tb.sv]
`timescale 1ns / 1ps

module ordered_list_engine_tb;
    import olist_pkg::*;

    localparam int LIST_CAPACITY  = DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS   = 540;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 3000;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    int          fail_count;
    int          outstanding;
    int          idle_cycles = 0;
    int          hold_req    = 0;
    bit          quiet_tx    = 1'b0;

    always #5 i_clk = ~i_clk;

    ordered_list_engine #(
        .CAPACITY(LIST_CAPACITY)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser)
    );

    ordered_list_checker #(
        .CAPACITY(LIST_CAPACITY)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : result_sink
        int stall_left;
        int hold_seen;
        int beats_in_mode;
        bit rx_quiet;
        stall_left    = 0;
        hold_seen     = 0;
        beats_in_mode = 30;
        rx_quiet      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_tready && m_tvalid) begin
                if (beats_in_mode == 0) begin
                    rx_quiet      = !rx_quiet;
                    beats_in_mode = $urandom_range(20, 60);
                end else begin
                    beats_in_mode--;
                end
                stall_left = rx_quiet ? 0 : $urandom_range(0, 8);
            end
            if (hold_req != hold_seen) begin
                hold_seen  = hold_req;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_op(input t_op op, input logic [7:0] pos, input logic [31:0] val);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, pos};
        s_tuser  <= op;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0, 1, 2: return 32'(int'($urandom_range(0, 15)) - 4);
            3:       return 32'h8000_0000 | 32'($urandom_range(0, 1));
            4:       return 32'h7FFF_FFFF - 32'($urandom_range(0, 1));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] rand_pos();
        case ($urandom_range(0, 9))
            0:       return 8'($urandom_range(128, 255));
            1:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(0, 66));
        endcase
    endfunction

    function automatic t_op pick_op(input bit growing);
        int roll;
        roll = $urandom_range(0, 99);
        if (growing) begin
            return (roll < 70) ? t_op'($urandom_range(0, 2)) : t_op'($urandom_range(3, 7));
        end
        if (roll < 60) return t_op'($urandom_range(3, 5));
        if (roll < 85) return t_op'($urandom_range(6, 7));
        return t_op'($urandom_range(0, 2));
    endfunction

    initial begin
        int          sent;
        int          phase_left;
        bit          growing;
        logic [31:0] tail_val;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list, then a few entries at the head, the tail and the edges of range.
        send_op(OP_REM_FIRST, 8'd0, 32'd0);
        send_op(OP_REM_LAST, 8'd0, 32'd0);
        send_op(OP_REM_AT, 8'd0, 32'd0);
        send_op(OP_GET, 8'd0, 32'd0);
        send_op(OP_GET, 8'hFF, 32'd0);
        send_op(OP_REM_AT, 8'h80, 32'd0);
        send_op(OP_FIND, 8'd0, 32'd0);
        send_op(OP_ADD_AT, 8'd1, 32'd9);
        send_op(OP_ADD_AT, 8'd0, 32'd5);
        send_op(OP_ADD_FIRST, 8'd0, 32'h7FFF_FFFF);
        send_op(OP_ADD_LAST, 8'd0, 32'h8000_0000);
        send_op(OP_ADD_AT, 8'd3, 32'hFFFF_FFFF);
        send_op(OP_ADD_AT, 8'h80, 32'd1);
        send_op(OP_ADD_AT, 8'h7F, 32'd1);
        send_op(OP_GET, 8'd0, 32'd0);
        send_op(OP_GET, 8'd3, 32'd0);
        send_op(OP_GET, 8'd4, 32'd0);
        send_op(OP_GET, 8'h7F, 32'd0);
        send_op(OP_FIND, 8'd0, 32'h8000_0000);
        send_op(OP_FIND, 8'd0, 32'd5);
        send_op(OP_REM_AT, 8'd4, 32'd0);
        send_op(OP_REM_AT, 8'd1, 32'd0);
        send_op(OP_REM_FIRST, 8'd0, 32'd0);
        send_op(OP_REM_LAST, 8'd0, 32'd0);
        send_op(OP_REM_AT, 8'd0, 32'd0);
        wait_drained();

        // The sink starts a long hold as the list begins to fill to capacity.
        hold_req++;
        tail_val = 32'd0;
        for (int n = 0; n < LIST_CAPACITY; n++) begin
            tail_val = rand_value();
            send_op(OP_ADD_LAST, rand_pos(), tail_val);
        end
        send_op(OP_ADD_FIRST, 8'd0, 32'd1);
        send_op(OP_ADD_LAST, 8'd0, 32'd1);
        send_op(OP_ADD_AT, 8'd0, 32'd1);
        send_op(OP_ADD_AT, 8'(LIST_CAPACITY + 1), 32'd1);
        send_op(OP_ADD_AT, 8'(LIST_CAPACITY), 32'd1);
        send_op(OP_ADD_AT, 8'hFF, 32'd1);
        send_op(OP_FIND, 8'd0, tail_val);
        send_op(OP_GET, 8'(LIST_CAPACITY - 1), 32'd0);
        send_op(OP_REM_AT, 8'(LIST_CAPACITY - 1), 32'd0);
        send_op(OP_GET, 8'(LIST_CAPACITY - 1), 32'd0);

        sent       = 0;
        phase_left = 0;
        growing    = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                growing    = !growing;
                phase_left = $urandom_range(60, 140);
                quiet_tx   = ($urandom_range(0, 3) == 0);
            end
            send_op(pick_op(growing), rand_pos(), rand_value());
            sent++;
            phase_left--;
            if (sent == RANDOM_ITEMS / 2) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
